// ===== hdl/json_string_unescaper_top_macros.svh =====
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPER_TOP_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Modes, result codes, result and decode structs, hex digit helper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_PLAIN = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_HEX0  = 3'd3,
    MODE_HEX1  = 3'd4,
    MODE_HEX2  = 3'd5,
    MODE_HEX3  = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_CLOSED    = 3'd1,
    ST_OPEN_EXP  = 3'd2,
    ST_BAD_ESC   = 3'd3,
    ST_BAD_HEX   = 3'd4,
    ST_NOT_CLOSE = 3'd5
  } status_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSpace = 8'h20;

  // results produced by one input item, up to three
  typedef struct packed {
    logic [1:0]      n;
    status_e         status;
    logic [2:0][7:0] bytes;
  } res_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] cu;
    res_t        res;
  } dec_t;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

// ===== hdl/json_string_unescaper_top.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper
// Streams raw bytes in, decoded UTF-8 string bytes and status codes out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while in_stall_o is low. Each byte passes an
// input register, a single decode step and a result buffer, from which its
// first result is offered. The output port gives one result per cycle while
// out_stall_i is low: a \u escape that encodes to two or three UTF-8 bytes
// holds the input while the result buffer drains; everything else sustains
// one byte per cycle with no gaps unless the output stalls. Status codes: 0
// data, 1 closed, 2 open expected, 3 bad escape, 4 bad hex, 5 not closed;
// last marks the final result of a byte.
`include "json_string_unescaper_top_macros.svh"

module json_string_unescaper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic        in_v_q;
  logic [7:0]  in_byte_q;
  logic        in_eoi_q;
  mode_e       mode_q;
  logic [15:0] cu_q;
  dec_t        dec;
  logic        buf_free, load;

  assign load       = in_v_q && buf_free;
  assign in_stall_o = in_v_q && !buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      mode_q <= MODE_IDLE;
      cu_q   <= '0;
    end else begin
      if (!in_stall_o) in_v_q <= in_valid_i;
      if (load) begin
        mode_q <= dec.mode;
        cu_q   <= dec.cu;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
      in_eoi_q  <= end_of_input_i;
    end
  end

  jsu_decode u_decode (
    .mode_i (mode_q),
    .cu_i   (cu_q),
    .byte_i (in_byte_q),
    .eoi_i  (in_eoi_q),
    .dec_o  (dec)
  );

  jsu_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (dec.res),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  `JSU_ASSERT_NOW(a_multi_from_hex, load && dec.res.n > 2'd1,
    mode_q == MODE_HEX3 && dec.res.status == ST_DATA, "multi-byte result outside \\u")
  `JSU_ASSERT_NOW(a_idle_eoi_silent, in_v_q && in_eoi_q && mode_q == MODE_IDLE,
    dec.res.n == 2'd0 && dec.mode == MODE_IDLE, "end of input in idle produced a result")
  `JSU_ASSERT_NEXT(a_error_to_idle,
    load && dec.res.n == 2'd1 && dec.res.status != ST_DATA,
    mode_q == MODE_IDLE, "error or close did not return to idle")

endmodule

// ===== hdl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper decode step
// Next mode, code unit and the results for one byte, combinational.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::mode_e mode_i,
  input  logic [15:0]    cu_i,
  input  logic [7:0]     byte_i,
  input  logic           eoi_i,
  output jsu_pkg::dec_t  dec_o
);
  import jsu_pkg::*;

  logic [4:0]  hv;
  logic [15:0] u;

  assign hv = hex_val(byte_i);
  assign u  = {cu_i[11:0], hv[3:0]};

  always_comb begin
    dec_o            = '0;
    dec_o.mode       = mode_i;
    dec_o.cu         = cu_i;
    dec_o.res.status = ST_DATA;
    case (mode_i)
      MODE_PLAIN, MODE_ESC, MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (eoi_i) begin
          dec_o.mode       = MODE_IDLE;
          dec_o.res.n      = 2'd1;
          dec_o.res.status = ST_NOT_CLOSE;
        end else if (mode_i == MODE_PLAIN) begin
          if (byte_i == ChBslash) begin
            dec_o.mode = MODE_ESC;
          end else if (byte_i == ChQuote) begin
            dec_o.mode       = MODE_IDLE;
            dec_o.res.n      = 2'd1;
            dec_o.res.status = ST_CLOSED;
          end else begin
            dec_o.res.n        = 2'd1;
            dec_o.res.bytes[0] = byte_i;
          end
        end else if (mode_i == MODE_ESC) begin
          dec_o.mode  = MODE_PLAIN;
          dec_o.res.n = 2'd1;
          case (byte_i)
            ChQuote, ChBslash, ChSlash: dec_o.res.bytes[0] = byte_i;
            8'h62: dec_o.res.bytes[0] = 8'h08;
            8'h66: dec_o.res.bytes[0] = 8'h0C;
            8'h6E: dec_o.res.bytes[0] = 8'h0A;
            8'h72: dec_o.res.bytes[0] = 8'h0D;
            8'h74: dec_o.res.bytes[0] = 8'h09;
            8'h75: begin
              dec_o.res.n = 2'd0;
              dec_o.cu    = '0;
              dec_o.mode  = MODE_HEX0;
            end
            default: begin
              dec_o.mode       = MODE_IDLE;
              dec_o.res.status = ST_BAD_ESC;
            end
          endcase
        end else if (!hv[4]) begin
          dec_o.mode       = MODE_IDLE;
          dec_o.res.n      = 2'd1;
          dec_o.res.status = ST_BAD_HEX;
        end else begin
          dec_o.cu = u;
          if (mode_i != MODE_HEX3) begin
            dec_o.mode = mode_e'(mode_i + 3'd1);
          end else begin
            dec_o.mode = MODE_PLAIN;
            if (u < 16'h0080) begin
              dec_o.res.n        = 2'd1;
              dec_o.res.bytes[0] = u[7:0];
            end else if (u < 16'h0800) begin
              dec_o.res.n        = 2'd2;
              dec_o.res.bytes[0] = {3'b110, u[10:6]};
              dec_o.res.bytes[1] = {2'b10, u[5:0]};
            end else begin
              dec_o.res.n        = 2'd3;
              dec_o.res.bytes[0] = {4'b1110, u[15:12]};
              dec_o.res.bytes[1] = {2'b10, u[11:6]};
              dec_o.res.bytes[2] = {2'b10, u[5:0]};
            end
          end
        end
      end
      default: begin
        // idle, and any unused code acts as idle
        dec_o.mode = MODE_IDLE;
        if (!eoi_i && byte_i != ChSpace && !(byte_i inside {[8'h09:8'h0D]})) begin
          if (byte_i == ChQuote) begin
            dec_o.mode = MODE_PLAIN;
          end else begin
            dec_o.res.n      = 2'd1;
            dec_o.res.status = ST_OPEN_EXP;
          end
        end
      end
    endcase
  end

endmodule

// ===== hdl/jsu_obuf.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper result buffer
// Holds the results of one item and hands them out one per transfer.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_top_macros.svh"

module jsu_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  jsu_pkg::res_t  res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic [2:0]     status_o,
  output logic           last_o
);
  import jsu_pkg::*;

  logic [1:0]      rem_q, idx_q;
  status_e         status_q;
  logic [2:0][7:0] bytes_q;
  logic            take;

  assign out_valid_o = (rem_q != 2'd0);
  assign take        = out_valid_o && !out_stall_i;
  // free when empty or the last pending result leaves this cycle
  assign free_o      = (rem_q == 2'd0) || (rem_q == 2'd1 && !out_stall_i);
  assign status_o    = status_q;
  assign last_o      = (rem_q == 2'd1);

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = bytes_q[0];
      2'd1:    out_byte_o = bytes_q[1];
      2'd2:    out_byte_o = bytes_q[2];
      default: out_byte_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      rem_q <= res_i.n;
      idx_q <= '0;
    end else if (take) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= res_i.status;
      bytes_q  <= res_i.bytes;
    end
  end

  `JSU_ASSERT_NOW(a_err_single, out_valid_o && status_q != ST_DATA, last_o,
    "non-data result is not alone")
  `JSU_ASSERT_NOW(a_idx_range, out_valid_o, ({1'b0, idx_q} + {1'b0, rem_q}) <= 3'd3,
    "result index past buffer")
  `JSU_ASSERT_NOW(a_no_overwrite, load_i, !out_valid_o || (last_o && take),
    "pending result overwritten")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Drives byte streams through the unescaper with random bursts and output
// stalls. A scoreboard decodes each accepted byte on its own and checks every
// result transfer against the oldest decoded result still waiting.
// ----------------------------------------------------------------------------
module tb_top;
  import jsu_pkg::*;

  localparam int unsigned RandomItems   = 200;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned ReportLimit   = 10;

  typedef struct packed {
    logic [7:0] data;
    status_e    code;
    logic       last;
  } result_t;

  typedef enum int unsigned {RX_FREE, RX_COIN, RX_EVERY3, RX_HEAVY} rx_pattern_e;

  class unescape_scoreboard;
    mode_e       mode;
    logic [15:0] unit;
    result_t     decoded_q[$];
    int unsigned mismatches;

    function new();
      mode       = MODE_IDLE;
      unit       = '0;
      mismatches = 0;
    endfunction

    static function bit is_space(logic [7:0] c);
      return c == ChSpace || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    static function int hex_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      return -1;
    endfunction

    function void put(logic [7:0] data, status_e code);
      result_t r;
      r.data = data;
      r.code = code;
      r.last = 1'b0;
      decoded_q = {decoded_q, r};
    endfunction

    // UTF-8 bytes of the gathered code unit; surrogates are encoded as is
    function void put_utf8();
      if (unit < 16'h0080) begin
        put(unit[7:0], ST_DATA);
      end else if (unit < 16'h0800) begin
        put({3'b110, unit[10:6]}, ST_DATA);
        put({2'b10, unit[5:0]}, ST_DATA);
      end else begin
        put({4'b1110, unit[15:12]}, ST_DATA);
        put({2'b10, unit[11:6]}, ST_DATA);
        put({2'b10, unit[5:0]}, ST_DATA);
      end
    endfunction

    // returns 0 for a byte that idle merely skips
    function bit decode_byte(logic [7:0] c, logic eoi);
      int          h;
      int unsigned n0;
      n0 = decoded_q.size();
      if (mode == MODE_IDLE) begin
        if (eoi || is_space(c)) return 1'b0;
        if (c == ChQuote) mode = MODE_PLAIN;
        else put(8'h00, ST_OPEN_EXP);
      end else if (eoi) begin
        mode = MODE_IDLE;
        put(8'h00, ST_NOT_CLOSE);
      end else begin
        case (mode)
          MODE_PLAIN: begin
            if (c == ChBslash) begin
              mode = MODE_ESC;
            end else if (c == ChQuote) begin
              mode = MODE_IDLE;
              put(8'h00, ST_CLOSED);
            end else begin
              put(c, ST_DATA);
            end
          end
          MODE_ESC: begin
            mode = MODE_PLAIN;
            case (c)
              ChQuote, ChBslash, ChSlash: put(c, ST_DATA);
              "b": put(8'h08, ST_DATA);
              "f": put(8'h0C, ST_DATA);
              "n": put(8'h0A, ST_DATA);
              "r": put(8'h0D, ST_DATA);
              "t": put(8'h09, ST_DATA);
              "u": begin
                unit = '0;
                mode = MODE_HEX0;
              end
              default: begin
                mode = MODE_IDLE;
                put(8'h00, ST_BAD_ESC);
              end
            endcase
          end
          default: begin
            h = hex_nibble(c);
            if (h < 0) begin
              mode = MODE_IDLE;
              put(8'h00, ST_BAD_HEX);
            end else begin
              unit = {unit[11:0], 4'(h)};
              case (mode)
                MODE_HEX0: mode = MODE_HEX1;
                MODE_HEX1: mode = MODE_HEX2;
                MODE_HEX2: mode = MODE_HEX3;
                default: begin
                  mode = MODE_PLAIN;
                  put_utf8();
                end
              endcase
            end
          end
        endcase
      end
      if (decoded_q.size() > n0) decoded_q[decoded_q.size() - 1].last = 1'b1;
      return 1'b1;
    endfunction

    function void check_output(logic [7:0] data, logic [2:0] code, logic last);
      result_t want;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result: byte %02h status %0d last %0b", data, code, last);
        return;
      end
      want = decoded_q.pop_front();
      if (data !== want.data || code !== want.code || last !== want.last) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("result mismatch: expected byte %02h status %0d last %0b, got %02h %0d %0b",
                   want.data, want.code, want.last, data, code, last);
      end
    endfunction

    function bit clean();
      if (decoded_q.size() != 0)
        $display("%0d decoded results never arrived", decoded_q.size());
      return mismatches == 0 && decoded_q.size() == 0;
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_eoi    = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [2:0] status_o;
  logic       last_o;

  unescape_scoreboard sb = new();
  int unsigned        active_items = 0;
  int unsigned        burst_left   = 0;
  int unsigned        idle_cycles  = 0;
  bit                 hold_req     = 1'b0;

  json_string_unescaper_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte),
    .end_of_input_i(in_eoi),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // transfers are seen with pre-edge values; inputs only move at negedge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o) begin
        if (sb.decode_byte(in_byte, in_eoi)) active_items++;
      end
      if (out_valid_o && !out_stall) sb.check_output(out_byte_o, status_o, last_o);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: runs of differing stall patterns, plus one long hold-off on request
  initial begin
    int unsigned run_left;
    int unsigned phase;
    rx_pattern_e pattern;
    run_left = 0;
    phase    = 0;
    pattern  = RX_FREE;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          pattern  = rx_pattern_e'($urandom_range(0, 3));
          run_left = $urandom_range(4, 40);
        end
        run_left--;
        phase++;
        case (pattern)
          RX_FREE:   out_stall <= 1'b0;
          RX_COIN:   out_stall <= 1'($urandom_range(0, 1));
          RX_EVERY3: out_stall <= (phase % 3 == 0);
          default:   out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_eoi   <= eoi;
    do @(posedge clk); while (in_stall_o);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (sb.decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return ChSpace;
      1:       return 8'h09;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 7))
      0:       return ChQuote;
      1:       return ChBslash;
      2:       return ChSlash;
      3:       return "b";
      4:       return "f";
      5:       return "n";
      6:       return "r";
      default: return "t";
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  task automatic send_unit(input logic [15:0] cu);
    send_item(ChBslash, 1'b0);
    send_item("u", 1'b0);
    send_item(hex_char(cu[15:12]), 1'b0);
    send_item(hex_char(cu[11:8]), 1'b0);
    send_item(hex_char(cu[7:4]), 1'b0);
    send_item(hex_char(cu[3:0]), 1'b0);
  endtask

  task automatic send_directed();
    // idle whitespace, a bad opening byte and a clean end of stream
    send_item(ChSpace, 1'b0);
    for (int c = 9; c <= 13; c++) send_item(8'(c), 1'b0);
    send_item("x", 1'b0);
    send_item(8'hFF, 1'b1);
    // byte extremes, a two-byte \u in mixed case, then close
    send_item(ChQuote, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(ChBslash, 1'b0);
    send_item("u", 1'b0);
    send_item("0", 1'b0);
    send_item("7", 1'b0);
    send_item("F", 1'b0);
    send_item("f", 1'b0);
    send_item(ChQuote, 1'b0);
    // unknown escape letter
    send_item(ChQuote, 1'b0);
    send_item(ChBslash, 1'b0);
    send_item("q", 1'b0);
    // non-hex digit inside \u
    send_item(ChQuote, 1'b0);
    send_item(ChBslash, 1'b0);
    send_item("u", 1'b0);
    send_item("g", 1'b0);
    // stream ends inside a string
    send_item(ChQuote, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // mostly well-formed strings with random content; a few break off early
  task automatic send_random_string();
    int unsigned segs;
    int unsigned kind;
    logic [15:0] cu;
    logic [7:0]  b;
    repeat ($urandom_range(0, 2)) send_item(pick_space(), 1'b0);
    if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0);
    if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b1);
    send_item(ChQuote, 1'b0);
    segs = $urandom_range(0, 8);
    for (int k = 0; k < segs; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        do b = 8'($urandom); while (b == ChQuote || b == ChBslash);
        send_item(b, 1'b0);
      end else if (kind < 65) begin
        send_item(ChBslash, 1'b0);
        send_item(pick_escape(), 1'b0);
      end else if (kind < 90) begin
        case ($urandom_range(0, 3))
          0: cu = 16'($urandom_range(0, 'h7F));
          1: cu = 16'($urandom_range('h80, 'h7FF));
          2: cu = 16'($urandom_range('h800, 'hFFFF));
          default: begin
            case ($urandom_range(0, 5))
              0:       cu = 16'h0000;
              1:       cu = 16'h007F;
              2:       cu = 16'h0080;
              3:       cu = 16'h07FF;
              4:       cu = 16'h0800;
              default: cu = 16'hFFFF;
            endcase
          end
        endcase
        send_unit(cu);
      end else if (kind < 94) begin
        do b = 8'($urandom);
        while (b inside {ChQuote, ChBslash, ChSlash, "b", "f", "n", "r", "t", "u"});
        send_item(ChBslash, 1'b0);
        send_item(b, 1'b0);
        return;
      end else if (kind < 97) begin
        send_item(ChBslash, 1'b0);
        send_item("u", 1'b0);
        repeat ($urandom_range(0, 3)) send_item(hex_char(4'($urandom)), 1'b0);
        do b = 8'($urandom); while (unescape_scoreboard::hex_nibble(b) >= 0);
        send_item(b, 1'b0);
        return;
      end else begin
        send_item(8'($urandom), 1'b1);
        return;
      end
    end
    send_item(ChQuote, 1'b0);
  endtask

  initial begin
    int unsigned base;
    bit          hold_done;
    bit          pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    send_directed();
    pause_until_drained();
    base = active_items;
    while (active_items - base < RandomItems) begin
      if (!hold_done && active_items - base >= RandomItems / 3) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && active_items - base >= 2 * RandomItems / 3) begin
        pause_until_drained();
        pause_done = 1'b1;
      end
      send_random_string();
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.clean()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
